/* design/gqsr_pkg.sv */
// Shared types, constants and grid tables for the grid qubit swap router.
// No dependencies; every other design file uses this package.
package gqsr_pkg;

    localparam int QUBIT_COUNT = 16;
    localparam int GRID_COLS   = 4;
    localparam int MAX_SWAPS   = 5;

    localparam int FW        = 4;                              // item field width
    localparam int PW        = $clog2(QUBIT_COUNT);            // position / index width
    localparam int GRID_ROWS = (QUBIT_COUNT + GRID_COLS - 1) / GRID_COLS;
    localparam int RW        = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW        = $clog2(GRID_COLS);
    localparam int EW        = $clog2(QUBIT_COUNT + GRID_COLS + 1); // room for cur + cols
    localparam int NW        = $clog2(MAX_SWAPS + 1);
    localparam int QX        = ((PW > FW) ? PW : FW) + 1;
    localparam int RED_STEPS = (1 << FW) / QUBIT_COUNT;

    typedef logic [PW-1:0] t_pos;
    typedef logic [EW-1:0] t_posx;
    typedef logic [RW-1:0] t_row;
    typedef logic [CW-1:0] t_col;
    typedef logic [QUBIT_COUNT-1:0][RW-1:0] t_row_tab;
    typedef logic [QUBIT_COUNT-1:0][CW-1:0] t_col_tab;

    typedef enum logic [1:0] {
        KIND_SWAP  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [FW-1:0] ctrl_logical;
        logic [FW-1:0] target_logical;
    } t_in_item;

    typedef struct packed {
        t_kind         kind;
        logic [FW-1:0] phys_a;
        logic [FW-1:0] phys_b;
        logic [FW-1:0] logical_a;
        logic [FW-1:0] logical_b;
        logic          was_direct;
        logic          last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // latch operands, read control position
        logic err_load;   // post equal-operand error result
        logic latch_cur;  // capture control position, read target position
        logic latch_dst;  // capture target position, clear swap count
        logic issue;      // capture next position, read its occupant
        logic step;       // commit one swap, post swap result
        logic finish;     // write back control, post done result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eq;         // reduced operands equal
        logic go;         // another swap step is due
        logic out_free;   // output register can take a result this cycle
    } t_sts;

    function automatic t_row_tab build_row_tab();
        t_row_tab t;
        int r;
        int c;
        r = 0;
        c = 0;
        for (int p = 0; p < QUBIT_COUNT; p++) begin
            t[p] = RW'(r);
            c++;
            if (c == GRID_COLS) begin
                c = 0;
                r++;
            end
        end
        return t;
    endfunction

    function automatic t_col_tab build_col_tab();
        t_col_tab t;
        int c;
        c = 0;
        for (int p = 0; p < QUBIT_COUNT; p++) begin
            t[p] = CW'(c);
            c++;
            if (c == GRID_COLS) begin
                c = 0;
            end
        end
        return t;
    endfunction

    localparam t_row_tab ROW_TAB = build_row_tab();
    localparam t_col_tab COL_TAB = build_col_tab();

    // logical index modulo qubit count by RED_STEPS conditional subtracts (one here)
    function automatic t_pos reduce_q(input logic [FW-1:0] v);
        logic [QX-1:0] t;
        t = QX'(v);
        for (int k = 0; k < RED_STEPS; k++) begin
            if (t >= QX'(QUBIT_COUNT)) begin
                t = t - QX'(QUBIT_COUNT);
            end
        end
        return t[PW-1:0];
    endfunction

    // position or index to a 4-bit item field (masked / zero extended)
    function automatic logic [FW-1:0] to_field(input t_pos p);
        logic [PW+FW-1:0] w;
        w = (PW+FW)'(p);
        return w[FW-1:0];
    endfunction

endpackage

/* design/grid_qubit_swap_router_core.sv */
// Grid qubit swap router, top level: controller plus datapath.
// Depends on gqsr_pkg, gqsr_ctrl, gqsr_datapath (and gqsr_map_ram below it).

// The router keeps the logical-to-physical qubit map and its inverse for a
// row-major grid, both identity after reset (no clearing pass: per-entry
// valid bits). Each item names a control and a target logical qubit
// (indices reduced modulo the qubit count). While the control's physical
// place is not a grid neighbour of the target's, the control moves one
// step, rows first then columns, up to five steps; each step swaps the map
// entries and produces a swap result, and a done result with last set
// closes the request. Equal operands give a single error result and leave
// the maps alone. An equal-operand item is handled in its accept step alone;
// any other item goes through accept, control and target lookups, then an
// evaluate step and a partner read per swap, and a final evaluate. This
// order comes from the single registered read port on each map store.
// Output stalls hold the sequence once the result register is full. The
// next item can be taken in the cycle after the done result is posted, if
// the output register is then empty or that result is being read out.
module grid_qubit_swap_router_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gqsr_pkg::t_in_item  i_in_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gqsr_pkg::t_out_item o_out_item
);

    gqsr_pkg::t_cmd cmd;
    gqsr_pkg::t_sts sts;

    // sequencer: owns the input handshake
    gqsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // maps, step logic and the result register
    gqsr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

/* design/gqsr_map_ram.sv */
// Qubit map store: one write port, one registered read port, identity after reset.
// Per-entry valid bits stand in for the reset contents. Uses gqsr_pkg.
module gqsr_map_ram (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wen,
    input  gqsr_pkg::t_pos   i_waddr,
    input  gqsr_pkg::t_pos   i_wdata,
    input  gqsr_pkg::t_pos   i_raddr,
    output gqsr_pkg::t_pos   o_rdata
);

    gqsr_pkg::t_pos                   r_mem [gqsr_pkg::QUBIT_COUNT];
    logic [gqsr_pkg::QUBIT_COUNT-1:0] r_valid;
    gqsr_pkg::t_pos                   r_rd;
    gqsr_pkg::t_pos                   r_ra;
    logic                             r_rv;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
        r_ra <= i_raddr;
        r_rv <= r_valid[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wen) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // never-written entry reads as its own index
    assign o_rdata = r_rv ? r_rd : r_ra;

endmodule

/* design/gqsr_datapath.sv */
// Router datapath: operand and position registers, step logic, both map stores,
// output register. Depends on gqsr_pkg and gqsr_map_ram.
module gqsr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gqsr_pkg::t_in_item  i_in_item,
    input  gqsr_pkg::t_cmd      i_cmd,
    output gqsr_pkg::t_sts      o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output gqsr_pkg::t_out_item o_out_item
);

    gqsr_pkg::t_pos      r_lc, r_lt, r_cur, r_dst, r_nxt;
    logic [gqsr_pkg::NW-1:0] r_n;
    logic                r_out_valid;
    gqsr_pkg::t_out_item r_out;

    gqsr_pkg::t_pos  in_lc, in_lt;
    gqsr_pkg::t_pos  l2p_raddr, l2p_waddr, l2p_wdata, l2p_rd;
    gqsr_pkg::t_pos  p2l_raddr, p2l_wdata, p2l_rd;
    logic            map_wen;

    gqsr_pkg::t_row  r1, r2, dr;
    gqsr_pkg::t_col  c1, c2, dc;
    gqsr_pkg::t_posx cur_x, up_x, col_x, nxt_x;
    logic            coupled, out_free;

    assign in_lc = gqsr_pkg::reduce_q(i_in_item.ctrl_logical);
    assign in_lt = gqsr_pkg::reduce_q(i_in_item.target_logical);

    // step toward target: rows first, columns when the row step leaves the grid
    always_comb begin
        r1    = gqsr_pkg::ROW_TAB[r_cur];
        c1    = gqsr_pkg::COL_TAB[r_cur];
        r2    = gqsr_pkg::ROW_TAB[r_dst];
        c2    = gqsr_pkg::COL_TAB[r_dst];
        dr    = (r1 > r2) ? (r1 - r2) : (r2 - r1);
        dc    = (c1 > c2) ? (c1 - c2) : (c2 - c1);
        coupled = ((dr == gqsr_pkg::RW'(1)) && (dc == '0)) ||
                  ((dr == '0) && (dc == gqsr_pkg::CW'(1)));
        cur_x = gqsr_pkg::EW'(r_cur);
        up_x  = cur_x + gqsr_pkg::EW'(gqsr_pkg::GRID_COLS);
        if (c1 < c2) begin
            col_x = cur_x + gqsr_pkg::EW'(1);
        end else if (c1 > c2) begin
            col_x = cur_x - gqsr_pkg::EW'(1);
        end else begin
            col_x = cur_x;
        end
        if (r1 < r2) begin
            nxt_x = (up_x >= gqsr_pkg::EW'(gqsr_pkg::QUBIT_COUNT)) ? col_x : up_x;
        end else if (r1 > r2) begin
            nxt_x = cur_x - gqsr_pkg::EW'(gqsr_pkg::GRID_COLS);
        end else begin
            nxt_x = col_x;
        end
    end

    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_sts.eq       = (in_lc == in_lt);
    assign o_sts.go       = (r_n < gqsr_pkg::NW'(gqsr_pkg::MAX_SWAPS)) && !coupled &&
                            (nxt_x != cur_x) &&
                            (nxt_x < gqsr_pkg::EW'(gqsr_pkg::QUBIT_COUNT));
    assign o_sts.out_free = out_free;

    // l2p is read at operand lookup; written with the partner move on a
    // swap and with the control's final place at the end
    assign map_wen   = i_cmd.step || i_cmd.finish;
    assign l2p_raddr = i_cmd.load_req ? in_lc : r_lt;
    assign l2p_waddr = i_cmd.step ? p2l_rd : r_lc;
    assign l2p_wdata = r_cur;
    assign p2l_raddr = i_cmd.issue ? nxt_x[gqsr_pkg::PW-1:0] : r_nxt;
    assign p2l_wdata = i_cmd.step ? p2l_rd : r_lc;

    gqsr_map_ram u_l2p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wen   (map_wen),
        .i_waddr (l2p_waddr),
        .i_wdata (l2p_wdata),
        .i_raddr (l2p_raddr),
        .o_rdata (l2p_rd)
    );

    gqsr_map_ram u_p2l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wen   (map_wen),
        .i_waddr (r_cur),
        .i_wdata (p2l_wdata),
        .i_raddr (p2l_raddr),
        .o_rdata (p2l_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_lc <= in_lc;
            r_lt <= in_lt;
        end
        if (i_cmd.latch_cur) begin
            r_cur <= l2p_rd;
        end else if (i_cmd.step) begin
            r_cur <= r_nxt;
        end
        if (i_cmd.latch_dst) begin
            r_dst <= l2p_rd;
        end
        if (i_cmd.issue) begin
            r_nxt <= nxt_x[gqsr_pkg::PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.latch_dst) begin
            r_n <= '0;
        end else if (i_cmd.step) begin
            r_n <= r_n + gqsr_pkg::NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.err_load || i_cmd.step || i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_load) begin
            r_out.kind       <= gqsr_pkg::KIND_ERROR;
            r_out.phys_a     <= '0;
            r_out.phys_b     <= '0;
            r_out.logical_a  <= gqsr_pkg::to_field(in_lc);
            r_out.logical_b  <= gqsr_pkg::to_field(in_lt);
            r_out.was_direct <= 1'b0;
            r_out.last       <= 1'b1;
        end else if (i_cmd.step) begin
            r_out.kind       <= gqsr_pkg::KIND_SWAP;
            r_out.phys_a     <= gqsr_pkg::to_field(r_cur);
            r_out.phys_b     <= gqsr_pkg::to_field(r_nxt);
            r_out.logical_a  <= gqsr_pkg::to_field(r_lc);
            r_out.logical_b  <= gqsr_pkg::to_field(p2l_rd);
            r_out.was_direct <= 1'b0;
            r_out.last       <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out.kind       <= gqsr_pkg::KIND_DONE;
            r_out.phys_a     <= gqsr_pkg::to_field(r_cur);
            r_out.phys_b     <= gqsr_pkg::to_field(r_dst);
            r_out.logical_a  <= gqsr_pkg::to_field(r_lc);
            r_out.logical_b  <= gqsr_pkg::to_field(r_lt);
            r_out.was_direct <= (r_n == '0);
            r_out.last       <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* design/gqsr_ctrl.sv */
// Router controller: one-hot sequencer for lookup, swap steps and completion.
// Talks to the datapath through gqsr_pkg command and status structs.
module gqsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  gqsr_pkg::t_sts i_sts,
    output gqsr_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK_C = 5'b00010,
        S_LOOK_T = 5'b00100,
        S_EVAL   = 5'b01000,
        S_READ   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_req = 1'b1;
                    if (i_sts.eq) begin
                        o_cmd.err_load = 1'b1;
                    end else begin
                        n_state = S_LOOK_C;
                    end
                end
            end
            S_LOOK_C: begin
                o_cmd.latch_cur = 1'b1;
                n_state         = S_LOOK_T;
            end
            S_LOOK_T: begin
                o_cmd.latch_dst = 1'b1;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.go) begin
                    o_cmd.issue = 1'b1;
                    n_state     = S_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/gqsr_checker.sv */
// Port-level checks for the grid qubit swap router, bound to the top level.
// Depends on gqsr_pkg and grid_qubit_swap_router_core.
module gqsr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input gqsr_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input gqsr_pkg::t_out_item o_out_item
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // nothing shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a pending swap result means the request is still routing
    a_swap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> o_in_stall)
        else $error("new item taken mid-route");

    // equal operands answer with an error result in the next cycle
    a_err_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (gqsr_pkg::reduce_q(i_in_item.ctrl_logical) ==
         gqsr_pkg::reduce_q(i_in_item.target_logical))
        |=> o_out_valid && (o_out_item.kind == gqsr_pkg::KIND_ERROR) && o_out_item.last)
        else $error("missing error result");

endmodule

bind grid_qubit_swap_router_core gqsr_checker u_checker (.*);

/* test/tb_grid_qubit_swap_router_core.sv */
// Self-checking testbench for grid_qubit_swap_router_core: routing requests in,
// swap/done/error items checked against an in-bench qubit map predictor.
// Depends on gqsr_pkg and the router RTL.
module tb_grid_qubit_swap_router_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 1000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES  = 20;    // settle time after the last result
    localparam int IDLE_PERCENT  = 6;
    localparam int LONG_HOLD     = 80;    // receiver hold-off for the fill-up test

    // Clock, reset and DUT ports. Every input is known from time zero.
    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    gqsr_pkg::t_in_item  i_in_item  = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    gqsr_pkg::t_out_item o_out_item;

    // Shared bench state
    gqsr_pkg::t_out_item pending_results[$];    // predicted items, oldest first
    logic [3:0] phys_of   [gqsr_pkg::QUBIT_COUNT];  // logical qubit -> physical position
    logic [3:0] logical_at[gqsr_pkg::QUBIT_COUNT];  // physical position -> logical qubit
    int         mismatch_count = 0;
    int         quiet_cycles   = 0;
    bit         idling_enabled = 1'b1;  // random gaps on both channels
    int         hold_request   = 0;     // receiver picks this up as a long hold-off
    int         hold_left      = 0;

    grid_qubit_swap_router_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Qubit map predictor
    // ------------------------------------------------------------------

    // Grid neighbors: Manhattan distance of exactly one on the row-major grid.
    function automatic bit grid_neighbors(input int a, input int b);
        int dr;
        int dc;
        dr = a / gqsr_pkg::GRID_COLS - b / gqsr_pkg::GRID_COLS;
        dc = a % gqsr_pkg::GRID_COLS - b % gqsr_pkg::GRID_COLS;
        if (dr < 0) dr = -dr;
        if (dc < 0) dc = -dc;
        return (dr + dc) == 1;
    endfunction

    // One move of the control toward the target: rows first, then columns.
    // A row move that would fall off a short last row turns into a column move.
    function automatic int step_toward(input int cur, input int dst);
        int r1;
        int c1;
        int r2;
        int c2;
        int col_move;
        int nxt;
        r1 = cur / gqsr_pkg::GRID_COLS;
        c1 = cur % gqsr_pkg::GRID_COLS;
        r2 = dst / gqsr_pkg::GRID_COLS;
        c2 = dst % gqsr_pkg::GRID_COLS;
        col_move = cur;
        if (c1 < c2) begin
            col_move = cur + 1;
        end else if (c1 > c2) begin
            col_move = cur - 1;
        end
        if (r1 < r2) begin
            nxt = cur + gqsr_pkg::GRID_COLS;
        end else if (r1 > r2) begin
            nxt = cur - gqsr_pkg::GRID_COLS;
        end else begin
            return col_move;
        end
        return (nxt >= gqsr_pkg::QUBIT_COUNT) ? col_move : nxt;
    endfunction

    function automatic void reset_qubit_maps();
        for (int i = 0; i < gqsr_pkg::QUBIT_COUNT; i++) begin
            phys_of[i]    = 4'(i);
            logical_at[i] = 4'(i);
        end
    endfunction

    // Works out every item one request produces and updates the maps.
    function automatic void route_request(input logic [3:0] ctrl_in,
                                          input logic [3:0] tgt_in);
        gqsr_pkg::t_out_item r;
        int lc;
        int lt;
        int cur;
        int dst;
        int nxt;
        int swaps;
        logic [3:0] la;
        logic [3:0] lb;
        lc = int'(ctrl_in) % gqsr_pkg::QUBIT_COUNT;
        lt = int'(tgt_in) % gqsr_pkg::QUBIT_COUNT;
        r = '0;
        // equal operands: one error item, maps untouched
        if (lc == lt) begin
            r.kind      = gqsr_pkg::KIND_ERROR;
            r.logical_a = 4'(lc);
            r.logical_b = 4'(lt);
            r.last      = 1'b1;
            pending_results.push_back(r);
            return;
        end
        cur   = int'(phys_of[lc]);
        dst   = int'(phys_of[lt]);
        swaps = 0;
        while (swaps < gqsr_pkg::MAX_SWAPS && !grid_neighbors(cur, dst)) begin
            nxt = step_toward(cur, dst);
            if (nxt == cur || nxt >= gqsr_pkg::QUBIT_COUNT) break;
            la = logical_at[cur];
            lb = logical_at[nxt];
            phys_of[la]     = 4'(nxt);
            phys_of[lb]     = 4'(cur);
            logical_at[cur] = lb;
            logical_at[nxt] = la;
            r = '0;
            r.kind      = gqsr_pkg::KIND_SWAP;
            r.phys_a    = 4'(cur);
            r.phys_b    = 4'(nxt);
            r.logical_a = la;
            r.logical_b = lb;
            pending_results.push_back(r);
            swaps++;
            cur = nxt;
        end
        // done item closes the request; positions as reached, even if the
        // swap budget ran out before the pair became neighbors
        r = '0;
        r.kind       = gqsr_pkg::KIND_DONE;
        r.phys_a     = 4'(cur);
        r.phys_b     = 4'(dst);
        r.logical_a  = 4'(lc);
        r.logical_b  = 4'(lt);
        r.was_direct = (swaps == 0);
        r.last       = 1'b1;
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got,
                               input logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Compares every accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        gqsr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind %0d", o_out_item.kind));
            end else begin
                want = pending_results.pop_front();
                check_field("kind",       4'(o_out_item.kind),       4'(want.kind));
                check_field("phys_a",     o_out_item.phys_a,         want.phys_a);
                check_field("phys_b",     o_out_item.phys_b,         want.phys_b);
                check_field("logical_a",  o_out_item.logical_a,      want.logical_a);
                check_field("logical_b",  o_out_item.logical_b,      want.logical_b);
                check_field("was_direct", 4'(o_out_item.was_direct), 4'(want.was_direct));
                check_field("last",       4'(o_out_item.last),       4'(want.last));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = idling_enabled && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one request (called at a falling edge), holds it until taken,
    // predicts its results and returns at the next falling edge with valid
    // still high so back-to-back items need no gap.
    task automatic send_request(input logic [3:0] ctrl_q, input logic [3:0] tgt_q);
        while (idling_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid               = 1'b1;
        i_in_item.ctrl_logical   = ctrl_q;
        i_in_item.target_logical = tgt_q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        route_request(ctrl_q, tgt_q);
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every predicted item has come back.
    task automatic wait_all_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Random request: mostly distinct pairs, some corner-to-corner routes
    // that need the full swap budget, a few equal-operand errors.
    task automatic send_random_request();
        int pick;
        int corner;
        logic [3:0] c;
        logic [3:0] t;
        pick = $urandom_range(0, 99);
        c    = 4'($urandom_range(0, 15));
        if (pick < 8) begin
            t = c;
        end else if (pick < 28) begin
            corner = $urandom_range(0, 3);
            corner = (corner[1] ? 12 : 0) + (corner[0] ? 3 : 0);
            c = logical_at[corner];
            t = logical_at[15 - corner];
        end else begin
            t = 4'(int'(c) + $urandom_range(1, 15));
        end
        send_request(c, t);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, errors, direct pairs and the longest routes.
    task automatic test_directed_routes();
        send_request(4'd0,  4'd0);    // equal operands at zero
        send_request(4'd15, 4'd15);   // equal operands at the top
        send_request(4'd0,  4'd1);    // already neighbors in a row
        send_request(4'd0,  4'd4);    // already neighbors in a column
        send_request(4'd0,  4'd15);   // corner to corner, full swap budget
        send_request(4'd15, 4'd0);
        send_request(4'd3,  4'd12);   // other diagonal
        send_request(4'd12, 4'd3);
        send_request(4'd5,  4'd10);
        send_request(4'd10, 4'd5);
        send_request(4'd7,  4'd8);
        send_request(4'd1,  4'd14);   // row moves then column moves
        send_request(4'd2,  4'd13);
        send_request(4'd4,  4'd11);
        send_request(4'd9,  4'd2);
        send_request(4'd15, 4'd14);
        send_request(4'd8,  4'd8);
        send_request(4'd6,  4'd9);
        send_request(4'd11, 4'd0);
        send_request(4'd14, 4'd1);
    endtask

    task automatic test_random_routes(input int count);
        for (int n = 0; n < count; n++) begin
            send_random_request();
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back(input int count);
        idling_enabled = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_random_request();
        end
        idling_enabled = 1'b1;
    endtask

    // Receiver holds off for a long time while requests keep coming, so the
    // result register fills and the block stalls its input.
    task automatic test_output_hold_off();
        hold_request = LONG_HOLD;
        for (int n = 0; n < 12; n++) begin
            send_random_request();
        end
    endtask

    // Sender goes quiet until everything is back, then resumes.
    task automatic test_drain_pause();
        for (int r = 0; r < 2; r++) begin
            for (int n = 0; n < 4; n++) begin
                send_random_request();
            end
            wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_qubit_maps();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_routes();
        test_random_routes(70);
        test_back_to_back(25);
        test_output_hold_off();
        test_drain_pause();
        test_random_routes(40);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
